// ===== sv/mbt_pkg.sv =====
package mbt_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 28;
    localparam int LIMIT_W    = 11;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd255;

    localparam int PROD_W = 2 * COORD_BITS;
    localparam int EXT_W  = PROD_W + 2;
    localparam int SQ_W   = PROD_W + 1;

    // |z|^2 > 4 on the raw squares: 4 * 2^(2F)
    localparam logic [SQ_W-1:0] ESC_THR =
        {{(SQ_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

    localparam int PC_W = 2;

    typedef enum logic [0:0] {
        S_IDLE,
        S_RUN
    } t_state;

    typedef enum logic [1:0] {
        MSEL_NONE,
        MSEL_RR,
        MSEL_II,
        MSEL_RI
    } t_msel;

    typedef struct packed {
        t_msel           msel;
        logic            chk;
        logic            upd;
        logic [PC_W-1:0] nxt;
    } t_uop;

    localparam logic [PC_W-1:0] PC_MUL_RR = 2'd0;
    localparam logic [PC_W-1:0] PC_MUL_II = 2'd1;
    localparam logic [PC_W-1:0] PC_MUL_RI = 2'd2;
    localparam logic [PC_W-1:0] PC_UPDATE = 2'd3;

    // Program for one z <- z*z + c step
    function automatic t_uop ucode(input logic [PC_W-1:0] pc);
        t_uop u;
        u = '{msel: MSEL_NONE, chk: 1'b0, upd: 1'b0, nxt: PC_MUL_RR};
        case (pc)
            PC_MUL_RR: u = '{msel: MSEL_RR,   chk: 1'b0, upd: 1'b0, nxt: PC_MUL_II};
            PC_MUL_II: u = '{msel: MSEL_II,   chk: 1'b0, upd: 1'b0, nxt: PC_MUL_RI};
            PC_MUL_RI: u = '{msel: MSEL_RI,   chk: 1'b1, upd: 1'b0, nxt: PC_UPDATE};
            PC_UPDATE: u = '{msel: MSEL_NONE, chk: 1'b0, upd: 1'b1, nxt: PC_MUL_RR};
            default:   u = '{msel: MSEL_NONE, chk: 1'b0, upd: 1'b0, nxt: PC_MUL_RR};
        endcase
        return u;
    endfunction

endpackage

// ===== sv/mandelbrot_membership_test_top.sv =====
// Mandelbrot membership test for one point c (signed Q4.28 per component).
// Input channel: i_in_valid / o_in_stall with i_c_real, i_c_imag. An item
// is taken when valid is high and stall is low; the block takes one point
// at a time and holds stall high while it iterates.
// Output channel: o_out_valid / i_out_stall with o_in_set. The result sits
// in an output register, so a new point may be taken while it waits.
// Each z <- z*z + c step runs through a 4-word microprogram on one shared
// 32x32 multiplier: three products (zr*zr, zi*zi, zr*zi) and one update
// step. The escape test reuses the squares of the next step.
// The number of steps n runs up to iteration_limit (255 after reset); a
// component overflow also ends the test. The block returns to idle as the
// result is written, so the next point can be taken while the result waits.
// When the receiver stalls with a result still held, a finishing point
// waits in its last microstep until the output register frees.
// i_cfg_we / i_cfg_wdata write iteration_limit; write only while idle.
// Reset (synchronous, active low) returns to idle, drops any held result
// and sets iteration_limit to 255.
module mandelbrot_membership_test_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [mbt_pkg::LIMIT_W-1:0]          i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [mbt_pkg::COORD_BITS-1:0] i_c_real,
    input  logic signed [mbt_pkg::COORD_BITS-1:0] i_c_imag,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_in_set
);

    localparam int CW = mbt_pkg::COORD_BITS;
    localparam int PW = mbt_pkg::PROD_W;
    localparam int EW = mbt_pkg::EXT_W;

    mbt_pkg::t_state r_state, n_state;
    logic [mbt_pkg::PC_W-1:0] r_pc, n_pc;
    logic [mbt_pkg::LIMIT_W-1:0] r_limit;
    logic [mbt_pkg::LIMIT_W-1:0] r_cnt;
    logic signed [CW-1:0] r_cr, r_ci, r_zr, r_zi;
    logic signed [PW-1:0] r_pr, r_pi, r_px;
    logic r_ovalid, r_oset;

    mbt_pkg::t_uop uop;
    logic signed [CW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic signed [EW-1:0] ext_pr, ext_pi, ext_px, ext_cr, ext_ci, nr, ni;
    logic [mbt_pkg::SQ_W-1:0] sq_sum;
    logic [mbt_pkg::LIMIT_W-1:0] cnt_inc;
    logic esc, fit, finish, fin_val, out_free, advance, in_acc;

    assign uop = mbt_pkg::ucode(r_pc);

    // Shared multiplier operand select
    always_comb begin
        mul_a = r_zr;
        mul_b = r_zr;
        case (uop.msel)
            mbt_pkg::MSEL_RR: begin
                mul_a = r_zr;
                mul_b = r_zr;
            end
            mbt_pkg::MSEL_II: begin
                mul_a = r_zi;
                mul_b = r_zi;
            end
            mbt_pkg::MSEL_RI: begin
                mul_a = r_zr;
                mul_b = r_zi;
            end
            default: begin
                mul_a = r_zr;
                mul_b = r_zr;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Squares are never negative: add as unsigned
    assign sq_sum = {1'b0, r_pr} + {1'b0, r_pi};
    assign esc    = sq_sum > mbt_pkg::ESC_THR;

    assign ext_pr = $signed({{2{r_pr[PW-1]}}, r_pr});
    assign ext_pi = $signed({{2{r_pi[PW-1]}}, r_pi});
    assign ext_px = $signed({{2{r_px[PW-1]}}, r_px});
    assign ext_cr = $signed({{(EW-CW){r_cr[CW-1]}}, r_cr});
    assign ext_ci = $signed({{(EW-CW){r_ci[CW-1]}}, r_ci});

    // Arithmetic shift floors toward minus infinity
    assign nr = (ext_pr >>> mbt_pkg::FRAC_BITS) - (ext_pi >>> mbt_pkg::FRAC_BITS) + ext_cr;
    assign ni = (ext_px >>> (mbt_pkg::FRAC_BITS - 1)) + ext_ci;

    assign fit = ((&nr[EW-1:CW-1]) || !(|nr[EW-1:CW-1]))
              && ((&ni[EW-1:CW-1]) || !(|ni[EW-1:CW-1]));

    assign cnt_inc = r_cnt + 1'b1;

    always_comb begin
        finish  = 1'b0;
        fin_val = 1'b0;
        if (r_state == mbt_pkg::S_RUN) begin
            if (uop.chk) begin
                if (r_cnt == r_limit) begin
                    finish  = 1'b1;
                    fin_val = 1'b1;
                end else if (esc) begin
                    finish  = 1'b1;
                    fin_val = 1'b0;
                end
            end
            if (uop.upd && !fit) begin
                finish  = 1'b1;
                fin_val = (cnt_inc == r_limit);
            end
        end
    end

    assign out_free = !r_ovalid || !i_out_stall;
    assign advance  = (r_state == mbt_pkg::S_RUN) && (!finish || out_free);

    // Next state
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        case (r_state)
            mbt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = mbt_pkg::S_RUN;
                    n_pc    = mbt_pkg::PC_MUL_RR;
                end
            end
            mbt_pkg::S_RUN: begin
                if (advance) begin
                    if (finish) begin
                        n_state = mbt_pkg::S_IDLE;
                    end else begin
                        n_pc = uop.nxt;
                    end
                end
            end
            default: begin
                n_state = mbt_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_in_stall = 1'b1;
        case (r_state)
            mbt_pkg::S_IDLE: o_in_stall = 1'b0;
            mbt_pkg::S_RUN:  o_in_stall = 1'b1;
            default:         o_in_stall = 1'b1;
        endcase
    end

    assign in_acc = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mbt_pkg::S_IDLE;
            r_pc     <= mbt_pkg::PC_MUL_RR;
            r_limit  <= mbt_pkg::LIMIT_RESET;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (advance && finish) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (in_acc) begin
                r_cnt <= '0;
            end else if (advance && uop.upd && fit) begin
                r_cnt <= cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cr <= i_c_real;
            r_ci <= i_c_imag;
            r_zr <= '0;
            r_zi <= '0;
        end else if (advance && uop.upd && fit) begin
            r_zr <= nr[CW-1:0];
            r_zi <= ni[CW-1:0];
        end
        if (advance) begin
            case (uop.msel)
                mbt_pkg::MSEL_RR: r_pr <= prod;
                mbt_pkg::MSEL_II: r_pi <= prod;
                mbt_pkg::MSEL_RI: r_px <= prod;
                default: ;
            endcase
        end
        if (advance && finish) begin
            r_oset <= fin_val;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_in_set    = r_oset;

endmodule

// ===== sv/mbt_checker.sv =====
module mbt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_in_set
);

    // Held result stays valid under stall
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // Held result does not change under stall
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_in_set))
        else $error("result changed while stalled");

    // Block goes busy right after taking a point
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("point taken while still idle");

    // A new result only comes out of a busy block
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a point in flight");

endmodule

bind mandelbrot_membership_test_top mbt_checker u_mbt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_in_set    (o_in_set)
);
